// File: rtl/core/adrr_pkg.sv
// Shared constants and control types for the speed reference ramp generator.
package adrr_pkg;

  localparam int unsigned REF_WIDTH_DEF = 24;
  localparam int unsigned TICK_W        = 24;
  localparam int unsigned CFG_IDX_W     = 1;

  localparam logic [TICK_W-1:0]    TICKS_RESET     = TICK_W'(10000);
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_TICKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECEL_TICKS = 1'b1;

  typedef enum logic {
    JOB_ACCEL = 1'b0,
    JOB_DECEL = 1'b1
  } job_e;

  typedef struct packed {
    logic load;
    logic div_start;
    job_e div_job;
    logic clr_accel;
    logic clr_decel;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic changed;
    logic reversal;
    logic mag_gt;
    logic mag_lt;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// File: rtl/core/adrr_if.sv
// Request and result channel interfaces of the ramp generator.
interface adrr_in_if #(
  parameter int unsigned RW = adrr_pkg::REF_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [RW-1:0] set_reference;
  logic                 drive_enabled;
  logic                 stop_command;

  modport source (output valid, set_reference, drive_enabled, stop_command, input ready);
  modport sink   (input valid, set_reference, drive_enabled, stop_command, output ready);
endinterface

interface adrr_out_if #(
  parameter int unsigned RW = adrr_pkg::REF_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [RW-1:0] out_reference;
  logic                 accelerating;
  logic                 decelerating;
  logic                 reverse_direction;

  modport source (output valid, out_reference, accelerating, decelerating, reverse_direction,
                  input ready);
  modport sink   (input valid, out_reference, accelerating, decelerating, reverse_direction,
                  output ready);
endinterface

// File: rtl/core/adrr_div.sv
// Bit-serial signed by unsigned divider, truncating, with a one-LSB minimum step.
module adrr_div #(
  parameter int unsigned DW = adrr_pkg::REF_WIDTH_DEF + 1,
  parameter int unsigned TW = adrr_pkg::TICK_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [DW-1:0] dividend_i,
  input  logic [TW-1:0]        divisor_i,
  output logic                 done_o,
  output logic signed [DW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [TW:0]     rem_q, rem_d;
  logic [DW-1:0]   quo_q, quo_d;
  logic [TW-1:0]   den_q, den_d;
  logic            neg_q, neg_d;
  logic            nz_q, nz_d;

  logic [TW:0]     rem_sh;
  logic            ge;
  logic [DW-1:0]   dvd_mag;
  logic [DW-1:0]   quo_neg;

  assign dvd_mag = dividend_i[DW-1] ? $unsigned(-dividend_i) : $unsigned(dividend_i);
  assign rem_sh  = {rem_q[TW-1:0], quo_q[DW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign quo_neg = -quo_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    nz_d   = nz_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DW);
      rem_d  = '0;
      quo_d  = dvd_mag;
      den_d  = (divisor_i == '0) ? TW'(1) : divisor_i;
      neg_d  = dividend_i[DW-1];
      nz_d   = dividend_i != '0;
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
    nz_q  <= nz_d;
  end

  always_comb begin
    if (quo_q == '0 && nz_q) begin
      quotient_o = neg_q ? '1 : DW'(1);
    end else begin
      quotient_o = neg_q ? $signed(quo_neg) : $signed(quo_q);
    end
  end

  assign done_o = done_q;

endmodule

// File: rtl/core/adrr_dp.sv
// Ramp datapath: tick registers, step registers, divider and output register.
module adrr_dp #(
  parameter int unsigned RW = adrr_pkg::REF_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [adrr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [adrr_pkg::TICK_W-1:0]        cfg_data_i,
  input  logic signed [RW-1:0]               set_reference_i,
  input  logic                               drive_enabled_i,
  input  logic                               stop_command_i,
  input  adrr_pkg::cmd_t                     cmd_i,
  output adrr_pkg::status_t                  status_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [RW-1:0]               out_reference_o,
  output logic                               accelerating_o,
  output logic                               decelerating_o,
  output logic                               reverse_direction_o
);

  import adrr_pkg::*;

  localparam int unsigned SW = RW + 1;
  localparam int unsigned OW = RW + 2;
  localparam logic signed [OW-1:0] OneW = OW'(1) <<< (RW - 2);
  localparam logic signed [OW-1:0] NegOneW = -OneW;
  localparam logic signed [RW-1:0] OneR = RW'(1) <<< (RW - 2);

  logic [TICK_W-1:0]    accel_ticks_q, decel_ticks_q;
  logic signed [RW-1:0] target_q;
  logic signed [RW-1:0] last_target_q;
  logic signed [SW-1:0] accel_step_q, decel_step_q;
  logic signed [RW-1:0] outref_q;
  logic                 acc_q, dec_q, out_valid_q;
  job_e                 job_q;

  logic                 t_pos, t_neg, o_pos, o_neg;
  logic [RW-1:0]        t_mag, o_mag;
  logic signed [SW-1:0] t_ext, o_ext, diff;
  logic [SW-1:0]        gap, a_mag, d_mag;
  logic                 reversal, mag_gt, mag_lt, snap;
  logic signed [SW-1:0] dividend;
  logic [TICK_W-1:0]    divisor;
  logic                 div_done;
  logic signed [SW-1:0] quotient;
  logic signed [OW-1:0] o_wide;
  logic signed [RW-1:0] o_next;
  logic                 acc_next, dec_next;

  assign t_neg = target_q[RW-1];
  assign t_pos = !target_q[RW-1] && (target_q != '0);
  assign o_neg = outref_q[RW-1];
  assign o_pos = !outref_q[RW-1] && (outref_q != '0);
  assign t_mag = t_neg ? $unsigned(-target_q) : $unsigned(target_q);
  assign o_mag = o_neg ? $unsigned(-outref_q) : $unsigned(outref_q);
  assign t_ext = {target_q[RW-1], target_q};
  assign o_ext = {outref_q[RW-1], outref_q};
  assign diff  = t_ext - o_ext;
  assign gap   = diff[SW-1] ? $unsigned(-diff) : $unsigned(diff);
  assign a_mag = accel_step_q[SW-1] ? $unsigned(-accel_step_q) : $unsigned(accel_step_q);
  assign d_mag = decel_step_q[SW-1] ? $unsigned(-decel_step_q) : $unsigned(decel_step_q);

  assign reversal = (t_pos && o_neg) || (t_neg && o_pos);
  assign mag_gt   = t_mag > o_mag;
  assign mag_lt   = t_mag < o_mag;
  assign snap     = (gap < d_mag) || (gap < a_mag);

  always_comb begin
    if (cmd_i.div_job == JOB_ACCEL) begin
      dividend = reversal ? t_ext : diff;
      divisor  = accel_ticks_q;
    end else begin
      dividend = reversal ? o_ext : -diff;
      divisor  = decel_ticks_q;
    end
  end

  adrr_div #(
    .DW (SW),
    .TW (TICK_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    acc_next = 1'b0;
    dec_next = 1'b0;
    if (snap) begin
      o_wide = OW'(target_q);
    end else if (reversal) begin
      o_wide   = OW'(outref_q) - OW'(decel_step_q);
      dec_next = 1'b1;
    end else if (mag_gt) begin
      o_wide   = OW'(outref_q) + OW'(accel_step_q);
      acc_next = 1'b1;
    end else if (mag_lt) begin
      o_wide   = OW'(outref_q) - OW'(decel_step_q);
      dec_next = 1'b1;
    end else begin
      o_wide = OW'(target_q);
    end
    if (o_wide > OneW) begin
      o_next = OneW[RW-1:0];
    end else if (o_wide < NegOneW) begin
      o_next = NegOneW[RW-1:0];
    end else begin
      o_next = o_wide[RW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_ticks_q <= TICKS_RESET;
      decel_ticks_q <= TICKS_RESET;
      last_target_q <= '0;
      accel_step_q  <= '0;
      decel_step_q  <= '0;
      outref_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ACCEL_TICKS: accel_ticks_q <= cfg_data_i;
          CFG_DECEL_TICKS: decel_ticks_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clr_accel) begin
        accel_step_q <= '0;
      end
      if (cmd_i.clr_decel) begin
        decel_step_q <= '0;
      end
      if (div_done) begin
        if (job_q == JOB_ACCEL) begin
          accel_step_q <= quotient;
        end else begin
          decel_step_q <= quotient;
        end
      end
      if (cmd_i.update) begin
        last_target_q <= target_q;
        outref_q      <= o_next;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      target_q <= (drive_enabled_i && !stop_command_i) ? set_reference_i : '0;
    end
    if (cmd_i.div_start) begin
      job_q <= cmd_i.div_job;
    end
    if (cmd_i.update) begin
      acc_q <= acc_next;
      dec_q <= dec_next;
    end
  end

  assign status_o.changed  = target_q != last_target_q;
  assign status_o.reversal = reversal;
  assign status_o.mag_gt   = mag_gt;
  assign status_o.mag_lt   = mag_lt;
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o         = out_valid_q;
  assign out_reference_o     = outref_q;
  assign accelerating_o      = acc_q;
  assign decelerating_o      = dec_q;
  assign reverse_direction_o = outref_q[RW-1];

  a_out_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (outref_q <= OneR) && (outref_q >= -OneR))
    else $error("ramp output beyond full scale");

endmodule

// File: rtl/core/adrr_ctrl.sv
// Ramp sequencer: accepts a request, runs the step divisions, commits the tick.
module adrr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  adrr_pkg::status_t  status_i,
  output adrr_pkg::cmd_t     cmd_o
);

  import adrr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_DIVA = 5'b00100,
    S_DIVD = 5'b01000,
    S_UPD  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!status_i.changed) begin
          state_d = S_UPD;
        end else if (status_i.reversal || status_i.mag_gt) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_job   = JOB_ACCEL;
          cmd_o.clr_decel = !status_i.reversal;
          state_d         = S_DIVA;
        end else if (status_i.mag_lt) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_job   = JOB_DECEL;
          cmd_o.clr_accel = 1'b1;
          state_d         = S_DIVD;
        end else begin
          cmd_o.clr_accel = 1'b1;
          cmd_o.clr_decel = 1'b1;
          state_d         = S_UPD;
        end
      end
      S_DIVA: begin
        if (status_i.div_done) begin
          if (status_i.reversal) begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_job   = JOB_DECEL;
            state_d         = S_DIVD;
          end else begin
            state_d = S_UPD;
          end
        end
      end
      S_DIVD: begin
        if (status_i.div_done) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (status_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_update_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |-> status_i.out_free)
    else $error("result committed over a pending result");

  a_diva_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVA && !status_i.div_done) |=> (state_q == S_DIVA))
    else $error("left accel division before it finished");

  a_load_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_EVAL))
    else $error("accepted request not evaluated");

endmodule

// File: rtl/core/accel_decel_ramp_reference.sv
// Top level of the acceleration / deceleration speed reference ramp generator.
// One request is one control sample tick and yields one result. A tick whose
// target equals the previous one goes from acceptance through evaluation to the
// update; a changed target that differs from the present output adds one
// bit-serial division before the update, or two on a sign reversal. The shared
// divider computes the acceleration and deceleration steps in turn. Results sit
// in an output register, so a new request is taken while a result waits; the
// next update stalls until that register is free.
module accel_decel_ramp_reference #(
  parameter int unsigned REF_WIDTH = adrr_pkg::REF_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [adrr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [adrr_pkg::TICK_W-1:0]    cfg_data_i,
  adrr_in_if.sink                        req_i,
  adrr_out_if.source                     rsp_o
);

  import adrr_pkg::*;

  cmd_t    cmd;
  status_t status;

  adrr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  adrr_dp #(
    .RW (REF_WIDTH)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .set_reference_i     (req_i.set_reference),
    .drive_enabled_i     (req_i.drive_enabled),
    .stop_command_i      (req_i.stop_command),
    .cmd_i               (cmd),
    .status_o            (status),
    .out_valid_o         (rsp_o.valid),
    .out_ready_i         (rsp_o.ready),
    .out_reference_o     (rsp_o.out_reference),
    .accelerating_o      (rsp_o.accelerating),
    .decelerating_o      (rsp_o.decelerating),
    .reverse_direction_o (rsp_o.reverse_direction)
  );

endmodule

// File: sim/ramp_tick_checker.sv
// Ramp generator checker: predicts each tick's result and compares it with the result channel.
module ramp_tick_checker
  import adrr_pkg::*;
#(
  parameter int unsigned RW = REF_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [TICK_W-1:0]    cfg_data_i,
  adrr_in_if                   req_mon_i,
  adrr_out_if                  rsp_mon_i,
  output int                   errors_o,
  output int                   awaited_o,
  output int                   accel_seen_o,
  output int                   decel_seen_o
);

  localparam longint FULL_SCALE = longint'(1) <<< (RW - 2);

  typedef struct packed {
    logic signed [RW-1:0] level;
    logic                 accel;
    logic                 decel;
    logic                 reverse;
  } tick_out_t;

  tick_out_t            awaited_ticks[$];
  logic [TICK_W-1:0]    up_ticks;
  logic [TICK_W-1:0]    down_ticks;
  logic signed [RW-1:0] prev_target;
  logic signed [RW-1:0] level;
  logic signed [RW:0]   up_step;
  logic signed [RW:0]   down_step;
  int                   errs;
  int                   accel_cnt;
  int                   decel_cnt;

  function automatic longint magn(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int sign_of(input longint v);
    return v > 0 ? 1 : (v < 0 ? -1 : 0);
  endfunction

  // Truncate toward zero, but never let a nonzero distance give a zero step.
  function automatic longint step_div(input longint span, input logic [TICK_W-1:0] ticks);
    longint d;
    longint q;
    d = (ticks == '0) ? 64'sd1 : longint'(ticks);
    q = span / d;
    if (q == 0 && span != 0) q = span > 0 ? 1 : -1;
    return q;
  endfunction

  function automatic tick_out_t predict_tick(input logic signed [RW-1:0] set_ref,
                                             input logic en, input logic stop);
    longint    tgt;
    longint    lvl;
    longint    gap_mag;
    logic      flip;
    tick_out_t res;
    tgt  = (en && !stop) ? longint'(set_ref) : 64'sd0;
    lvl  = longint'(level);
    flip = (sign_of(tgt) * sign_of(lvl)) < 0;
    res  = '0;
    if (tgt != longint'(prev_target)) begin
      if (flip) begin
        up_step   = (RW+1)'(step_div(tgt, up_ticks));
        down_step = (RW+1)'(step_div(lvl, down_ticks));
      end else if (magn(tgt) > magn(lvl)) begin
        up_step   = (RW+1)'(step_div(tgt - lvl, up_ticks));
        down_step = '0;
      end else if (magn(tgt) < magn(lvl)) begin
        up_step   = '0;
        down_step = (RW+1)'(step_div(lvl - tgt, down_ticks));
      end else begin
        up_step   = '0;
        down_step = '0;
      end
    end
    prev_target = RW'(tgt);
    gap_mag = magn(tgt - lvl);
    if (gap_mag < magn(longint'(down_step)) || gap_mag < magn(longint'(up_step))) begin
      lvl = tgt;
    end else if (flip) begin
      lvl = lvl - longint'(down_step);
      res.decel = 1'b1;
    end else if (magn(tgt) > magn(lvl)) begin
      lvl = lvl + longint'(up_step);
      res.accel = 1'b1;
    end else if (magn(tgt) < magn(lvl)) begin
      lvl = lvl - longint'(down_step);
      res.decel = 1'b1;
    end else begin
      lvl = tgt;
    end
    if (lvl > FULL_SCALE) lvl = FULL_SCALE;
    if (lvl < -FULL_SCALE) lvl = -FULL_SCALE;
    level       = RW'(lvl);
    res.level   = RW'(lvl);
    res.reverse = lvl < 0;
    return res;
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errs++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tick_out_t want;
    if (!rst_ni) begin
      awaited_ticks.delete();
      up_ticks    = TICKS_RESET;
      down_ticks  = TICKS_RESET;
      prev_target = '0;
      level       = '0;
      up_step     = '0;
      down_step   = '0;
      errs        = 0;
      accel_cnt   = 0;
      decel_cnt   = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ACCEL_TICKS) up_ticks = cfg_data_i;
        if (cfg_idx_i == CFG_DECEL_TICKS) down_ticks = cfg_data_i;
      end
      if (rsp_mon_i.valid && rsp_mon_i.ready) begin
        if (awaited_ticks.size() == 0) begin
          errs++;
          $display("%0t: result with no tick awaited, expected none, got level %0d",
                   $time, rsp_mon_i.out_reference);
        end else begin
          want = awaited_ticks.pop_front();
          check_field("out_reference", longint'(want.level),
                      longint'(rsp_mon_i.out_reference));
          check_field("accelerating", want.accel, rsp_mon_i.accelerating);
          check_field("decelerating", want.decel, rsp_mon_i.decelerating);
          check_field("reverse_direction", want.reverse, rsp_mon_i.reverse_direction);
          accel_cnt += want.accel;
          decel_cnt += want.decel;
        end
      end
      if (req_mon_i.valid && req_mon_i.ready) begin
        awaited_ticks.push_back(predict_tick(req_mon_i.set_reference,
                                             req_mon_i.drive_enabled,
                                             req_mon_i.stop_command));
      end
    end
    errors_o     <= errs;
    awaited_o    <= awaited_ticks.size();
    accel_seen_o <= accel_cnt;
    decel_seen_o <= decel_cnt;
  end

endmodule

// File: sim/testbench.sv
// Testbench top: drives ramp ticks and tick-count settings, and reports the verdict.
module testbench;
  import adrr_pkg::*;

  localparam int REF_W          = REF_WIDTH_DEF;
  localparam int ONE            = 1 << (REF_W - 2);
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_TICKS    = 108;

  localparam logic signed [REF_W-1:0] TOP_CODE    = {1'b0, {(REF_W-1){1'b1}}};
  localparam logic signed [REF_W-1:0] BOTTOM_CODE = {1'b1, {(REF_W-1){1'b0}}};
  localparam logic signed [REF_W-1:0] ONE_REF     = REF_W'(ONE);
  localparam logic signed [REF_W-1:0] NEG_ONE_REF = -ONE_REF;
  localparam logic [TICK_W-1:0]       MAX_TICKS   = {TICK_W{1'b1}};

  logic                    clk_i      = 1'b0;
  logic                    rst_ni     = 1'b0;
  logic                    cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i  = CFG_ACCEL_TICKS;
  logic [TICK_W-1:0]       cfg_data_i = '0;
  logic                    push_valid = 1'b0;
  logic signed [REF_W-1:0] push_ref   = '0;
  logic                    push_en    = 1'b0;
  logic                    push_stop  = 1'b0;
  logic                    take_rsp   = 1'b0;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int stall_left   = 0;
  int quiet_cycles = 0;
  int tick_count   = 0;
  int settings     = 0;
  int errors;
  int awaited;
  int accel_seen;
  int decel_seen;

  adrr_in_if  #(.RW(REF_W)) req_ch ();
  adrr_out_if #(.RW(REF_W)) rsp_ch ();

  assign req_ch.valid         = push_valid;
  assign req_ch.set_reference = push_ref;
  assign req_ch.drive_enabled = push_en;
  assign req_ch.stop_command  = push_stop;
  assign rsp_ch.ready         = take_rsp;

  accel_decel_ramp_reference #(.REF_WIDTH(REF_W)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  ramp_tick_checker #(.RW(REF_W)) checker_u (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .req_mon_i    (req_ch),
    .rsp_mon_i    (rsp_ch),
    .errors_o     (errors),
    .awaited_o    (awaited),
    .accel_seen_o (accel_seen),
    .decel_seen_o (decel_seen)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int gap_len();
    return ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(3, 1);
  endfunction

  function automatic logic [TICK_W-1:0] pick_ticks();
    int r;
    r = $urandom_range(99);
    if (r < 80) return TICK_W'($urandom_range(16, 1));
    if (r < 95) return TICK_W'($urandom_range(400, 17));
    return TICK_W'($urandom_range(MAX_TICKS, 1));
  endfunction

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      take_rsp   <= 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      stall_left <= gap_len() - 1;
      take_rsp   <= 1'b0;
    end else begin
      take_rsp <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (push_valid && req_ch.ready) || (rsp_ch.valid && take_rsp)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tick(input logic signed [REF_W-1:0] tgt, input logic en, input logic stop);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? gap_len() : 0;
    if (gap != 0) begin
      push_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_valid <= 1'b1;
    push_ref   <= tgt;
    push_en    <= en;
    push_stop  <= stop;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    tick_count++;
  endtask

  task automatic drain();
    push_valid <= 1'b0;
    @(posedge clk_i);
    while (awaited != 0) @(posedge clk_i);
  endtask

  task automatic set_ticks(input logic [TICK_W-1:0] up, input logic [TICK_W-1:0] down);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ACCEL_TICKS;
    cfg_data_i <= up;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_DECEL_TICKS;
    cfg_data_i <= down;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  initial begin
    int                      left;
    int                      dwell;
    longint                  pick;
    logic signed [REF_W-1:0] tgt;
    logic                    en;
    logic                    stop;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset tick counts: full swings, reversal, one-LSB step, forced zero, beyond full scale
    idle_pct  = 20;
    stall_pct = 20;
    send_tick(ONE_REF, 1'b1, 1'b0);
    send_tick(ONE_REF, 1'b1, 1'b0);
    send_tick(NEG_ONE_REF, 1'b1, 1'b0);
    send_tick(NEG_ONE_REF, 1'b1, 1'b0);
    send_tick(REF_W'(1), 1'b1, 1'b0);
    send_tick(ONE_REF, 1'b0, 1'b0);
    send_tick(ONE_REF, 1'b1, 1'b1);
    send_tick(TOP_CODE, 1'b1, 1'b0);
    send_tick(BOTTOM_CODE, 1'b1, 1'b0);
    send_tick('0, 1'b1, 1'b0);

    // one-tick ramps: full-scale jumps, clamping
    drain();
    set_ticks(TICK_W'(1), TICK_W'(1));
    send_tick(ONE_REF, 1'b1, 1'b0);
    send_tick(NEG_ONE_REF, 1'b1, 1'b0);
    send_tick(NEG_ONE_REF, 1'b1, 1'b0);
    send_tick(TOP_CODE, 1'b1, 1'b0);
    send_tick(TOP_CODE, 1'b1, 1'b0);
    send_tick(ONE_REF, 1'b1, 1'b1);

    // zero tick counts act as one
    drain();
    set_ticks('0, '0);
    send_tick(REF_W'(-3), 1'b1, 1'b0);
    send_tick(BOTTOM_CODE, 1'b1, 1'b0);
    send_tick('0, 1'b0, 1'b1);

    // longest ramps: steps truncate to one LSB
    drain();
    set_ticks(MAX_TICKS, MAX_TICKS);
    send_tick(ONE_REF, 1'b1, 1'b0);
    send_tick(NEG_ONE_REF, 1'b1, 1'b0);
    send_tick('0, 1'b1, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      set_ticks(pick_ticks(), pick_ticks());
      idle_pct  = (ph == 1) ? 0 : 25;
      stall_pct = (ph == 1) ? 0 : 25;
      left = PHASE_TICKS;
      while (left > 0) begin
        case ($urandom_range(9))
          0:       pick = 0;
          1:       pick = $urandom_range(1) ? ONE : -ONE;
          2:       pick = longint'($urandom);
          3:       pick = longint'($urandom_range(40)) - 20;
          default: pick = longint'($urandom_range(2 * ONE)) - ONE;
        endcase
        tgt   = REF_W'(pick);
        en    = $urandom_range(9) != 0;
        stop  = $urandom_range(9) == 0;
        dwell = $urandom_range(24, 1);
        for (int k = 0; k < dwell && left > 0; k++) begin
          if ($urandom_range(9) == 0) begin
            send_tick(tgt, 1'($urandom_range(1)), 1'($urandom_range(1)));
          end else begin
            send_tick(tgt, en, stop);
          end
          left--;
          // hold off until the pipe is empty, then resume
          if (ph == 3 && left == PHASE_TICKS / 2) drain();
        end
      end
    end

    drain();
    repeat (60) @(posedge clk_i);
    $display("covered %0d ticks over %0d tick-count settings (reset, zero, one, max, random)",
             tick_count, settings + 1);
    $display("results: %0d accelerating, %0d decelerating", accel_seen, decel_seen);
    if (errors == 0 && awaited == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
